### rtl/sharpen_pkg.sv
// shared types and constants for the 5-point laplacian sharpening stream
// no dependencies
package sharpen_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;
  localparam int unsigned DIM_MIN        = 3;
  localparam int unsigned DIM_RST        = 1024;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned KGAIN      = 5;

  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);
  localparam int unsigned PUSH_W     = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  // one column of the two line stores
  typedef struct packed {
    logic [PIX_W-1:0] two_above;
    logic [PIX_W-1:0] above;
  } line_t;

  typedef struct packed {
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] left;
  } ops_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               has_up;
    logic               last_row;
    logic               interior;
    logic               eof;
  } info_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pix;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
    logic               eof;
  } res_t;

endpackage

### rtl/sharpen_ctrl.sv
// frame geometry registers, row and column counters, line store addressing
// depends on sharpen_pkg
module sharpen_ctrl import sharpen_pkg::*; #(
  parameter int unsigned MaxWidth  = MAX_WIDTH_DEF,
  parameter int unsigned MaxHeight = MAX_HEIGHT_DEF,
  localparam int unsigned AW = $clog2(MaxWidth),
  localparam int unsigned RW = $clog2(MaxHeight)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  accept_i,
  output logic [AW-1:0]         wr_addr_o,
  output logic [AW-1:0]         rd_addr_o,
  output info_t                 info_o
);

  localparam int unsigned DW   = $clog2(MaxWidth + 1);
  localparam int unsigned HW   = $clog2(MaxHeight + 1);
  localparam int unsigned PW   = DW + 1;
  localparam int unsigned WRst = (DIM_RST > MaxWidth) ? MaxWidth : DIM_RST;
  localparam int unsigned HRst = (DIM_RST > MaxHeight) ? MaxHeight : DIM_RST;

  logic [DW-1:0] width_q, width_d;
  logic [HW-1:0] height_q, height_d;
  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic [31:0]   cfg_val, w_clamp, h_clamp;
  logic [DW-1:0] col_p1;
  logic [PW-1:0] col_p2, col_p2_wrap;
  logic [HW-1:0] row_p1;
  logic          last_row;
  logic [31:0]   row_ext, col_ext;

  assign cfg_ready_o = 1'b1;

  assign cfg_val = 32'(cfg_wdata_i);
  assign w_clamp = (cfg_val < DIM_MIN) ? DIM_MIN : (cfg_val > MaxWidth) ? MaxWidth : cfg_val;
  assign h_clamp = (cfg_val < DIM_MIN) ? DIM_MIN : (cfg_val > MaxHeight) ? MaxHeight : cfg_val;

  assign col_p1   = DW'(col_q) + DW'(1);
  assign row_p1   = HW'(row_q) + HW'(1);
  assign last_row = (row_p1 >= height_q);

  // prefetch two positions ahead in raster order
  assign col_p2      = PW'(col_q) + PW'(2);
  assign col_p2_wrap = (col_p2 >= PW'(width_q)) ? col_p2 - PW'(width_q) : col_p2;
  assign rd_addr_o   = col_p2_wrap[AW-1:0];
  assign wr_addr_o   = col_q;

  assign row_ext = 32'(row_q);
  assign col_ext = 32'(col_q);

  always_comb begin
    info_o.row      = row_ext[COORD_W-1:0];
    info_o.col      = col_ext[COORD_W-1:0];
    info_o.has_up   = (row_q != '0);
    info_o.last_row = last_row;
    info_o.interior = (HW'(row_q) >= HW'(2)) && (HW'(row_q) < height_q) &&
                      (col_q != '0) && (col_p1 < width_q);
    info_o.eof      = (col_p1 >= width_q);
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_FRAME_WIDTH: begin
          width_d = DW'(w_clamp);
          col_d   = '0;
          row_d   = '0;
        end
        REG_FRAME_HEIGHT: begin
          height_d = HW'(h_clamp);
          col_d    = '0;
          row_d    = '0;
        end
        default: ;
      endcase
    end else if (accept_i) begin
      if (col_p1 >= width_q) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DW'(WRst);
      height_q <= HW'(HRst);
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DW'(col_q) < width_q)
    else $error("column counter beyond frame width");

  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    HW'(row_q) < height_q)
    else $error("row counter beyond frame height");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> rd_addr_o != wr_addr_o)
    else $error("line store read and write hit the same column");

endmodule

### rtl/sharpen_linebuf.sv
// two line stores packed in one memory, plus the cross window registers
// depends on sharpen_pkg
module sharpen_linebuf import sharpen_pkg::*; #(
  parameter int unsigned MaxWidth = MAX_WIDTH_DEF,
  localparam int unsigned AW = $clog2(MaxWidth)
) (
  input  logic             clk_i,
  input  logic             accept_i,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [AW-1:0]    rd_addr_i,
  output ops_t             ops_o
);

  line_t            mem [MaxWidth];
  line_t            rd_q;
  line_t            cur_q;
  logic [PIX_W-1:0] left_q;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      mem[wr_addr_i] <= {cur_q.above, pixel_i};
      rd_q           <= mem[rd_addr_i];
      cur_q          <= rd_q;
      left_q         <= cur_q.above;
    end
  end

  always_comb begin
    ops_o.up     = cur_q.two_above;
    ops_o.centre = cur_q.above;
    ops_o.right  = rd_q.above;
    ops_o.left   = left_q;
  end

endmodule

### rtl/sharpen_core.sv
// input register and kernel arithmetic, forms up to two results per item
// depends on sharpen_pkg
module sharpen_core import sharpen_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      pixel_i,
  input  ops_t                  ops_i,
  input  info_t                 info_i,
  input  logic [OUTQ_CNT_W-1:0] free_i,
  output logic [PUSH_W-1:0]     push_cnt_o,
  output res_t                  res0_o,
  output res_t                  res1_o
);

  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_pix_q;
  ops_t             s1_ops_q;
  info_t            s1_info_q;

  logic [PUSH_W-1:0] n_res;
  logic              advance;
  logic              accept;
  logic [10:0]       gain_term;
  logic [9:0]        neigh;
  logic signed [11:0] diff;
  logic [PIX_W-1:0]  sat;
  res_t              up_res, low_res;

  assign n_res      = PUSH_W'(s1_info_q.has_up) + PUSH_W'(s1_info_q.last_row);
  assign advance    = s1_valid_q && (OUTQ_CNT_W'(n_res) <= free_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pixel_i;
      s1_ops_q  <= ops_i;
      s1_info_q <= info_i;
    end
  end

  // 5*centre minus the four neighbors, down is the incoming pixel
  assign gain_term = 11'(s1_ops_q.centre) * 11'(KGAIN);
  assign neigh     = 10'(s1_ops_q.left) + 10'(s1_ops_q.right) +
                     10'(s1_ops_q.up) + 10'(s1_pix_q);
  assign diff      = $signed({1'b0, gain_term}) - $signed({2'b00, neigh});

  always_comb begin
    if (diff < 12'sd0) begin
      sat = '0;
    end else if (diff > 12'sd255) begin
      sat = '1;
    end else begin
      sat = diff[PIX_W-1:0];
    end
  end

  always_comb begin
    up_res.pix  = s1_info_q.interior ? sat : '0;
    up_res.row  = s1_info_q.row - COORD_W'(1);
    up_res.col  = s1_info_q.col;
    up_res.last = !s1_info_q.last_row;
    up_res.eof  = 1'b0;

    low_res.pix  = '0;
    low_res.row  = s1_info_q.row;
    low_res.col  = s1_info_q.col;
    low_res.last = 1'b1;
    low_res.eof  = s1_info_q.eof;
  end

  assign res0_o     = s1_info_q.has_up ? up_res : low_res;
  assign res1_o     = low_res;
  assign push_cnt_o = advance ? n_res : '0;

  a_hold_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_info_q) && $stable(s1_pix_q))
    else $error("stalled item changed in the input register");

endmodule

### rtl/sharpen_outq.sv
// small result queue, takes up to two results a cycle and hands out one
// depends on sharpen_pkg
module sharpen_outq import sharpen_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [PUSH_W-1:0]     push_cnt_i,
  input  res_t                  res0_i,
  input  res_t                  res1_i,
  output logic [OUTQ_CNT_W-1:0] free_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output res_t                  res_o
);

  localparam int unsigned PW = $clog2(OUTQ_DEPTH);

  res_t                  q_mem [OUTQ_DEPTH];
  logic [PW-1:0]         wp_q, rp_q;
  logic [OUTQ_CNT_W-1:0] cnt_q;
  logic                  pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign free_o      = OUTQ_CNT_W'(OUTQ_DEPTH) - cnt_q;
  assign res_o       = q_mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != '0) begin
      q_mem[wp_q] <= res0_i;
    end
    if (push_cnt_i > PUSH_W'(1)) begin
      q_mem[wp_q + PW'(1)] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + PW'(push_cnt_i);
      rp_q  <= rp_q + PW'(pop);
      cnt_q <= cnt_q + OUTQ_CNT_W'(push_cnt_i) - OUTQ_CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    OUTQ_CNT_W'(push_cnt_i) <= free_o)
    else $error("result queue overflow");

endmodule

### rtl/sharpen_3x3_cross_stream.sv
// 5-point laplacian sharpening of a raster pixel stream, top level
// path: an accepted item is held in the core input register until the
// result queue has room for its results, then they are queued and offered
// throughput: one item per cycle while the result queue has room; on the
// last row two results per item, so the output port sets the pace there
// reset: counters and handshake state clear, geometry returns to full size,
// line stores are not cleared and fill as the first rows pass
module sharpen_3x3_cross_stream import sharpen_pkg::*; #(
  parameter int unsigned MaxWidth  = MAX_WIDTH_DEF,
  parameter int unsigned MaxHeight = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      pixel_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIX_W-1:0]      pixel_out_o,
  output logic [COORD_W-1:0]    out_row_o,
  output logic [COORD_W-1:0]    out_col_o,
  output logic                  last_in_run_o,
  output logic                  end_of_frame_o
);

  localparam int unsigned AW = $clog2(MaxWidth);

  logic                  accept;
  logic [AW-1:0]         wr_addr, rd_addr;
  info_t                 info;
  ops_t                  ops;
  logic [OUTQ_CNT_W-1:0] free;
  logic [PUSH_W-1:0]     push_cnt;
  res_t                  res0, res1, res_out;

  assign accept = in_valid_i && in_ready_o;

  sharpen_ctrl #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .wr_addr_o   (wr_addr),
    .rd_addr_o   (rd_addr),
    .info_o      (info)
  );

  sharpen_linebuf #(
    .MaxWidth (MaxWidth)
  ) u_linebuf (
    .clk_i     (clk_i),
    .accept_i  (accept),
    .pixel_i   (pixel_in_i),
    .wr_addr_i (wr_addr),
    .rd_addr_i (rd_addr),
    .ops_o     (ops)
  );

  sharpen_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_i    (pixel_in_i),
    .ops_i      (ops),
    .info_i     (info),
    .free_i     (free),
    .push_cnt_o (push_cnt),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  sharpen_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .res0_i      (res0),
    .res1_i      (res1),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign pixel_out_o    = res_out.pix;
  assign out_row_o      = res_out.row;
  assign out_col_o      = res_out.col;
  assign last_in_run_o  = res_out.last;
  assign end_of_frame_o = res_out.eof;

endmodule

### verif/sharpen_3x3_cross_stream_test.sv
// self-checking testbench for the 5-point laplacian sharpening stream
// predicts every result from its own line stores and frame counters
// depends on sharpen_pkg and sharpen_3x3_cross_stream
module sharpen_3x3_cross_stream_test;
  import sharpen_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [PIX_W-1:0]      pixel_in_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [PIX_W-1:0]      pixel_out_o;
  logic [COORD_W-1:0]    out_row_o;
  logic [COORD_W-1:0]    out_col_o;
  logic                  last_in_run_o;
  logic                  end_of_frame_o;

  sharpen_3x3_cross_stream u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_in_i     (pixel_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_out_o    (pixel_out_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .last_in_run_o  (last_in_run_o),
    .end_of_frame_o (end_of_frame_o)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [PIX_W-1:0]      prev2_line [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]      prev_line  [MAX_WIDTH_DEF];
  int unsigned           cur_row, cur_col;
  logic [CFG_DATA_W-1:0] width_reg  = CFG_DATA_W'(DIM_RST);
  logic [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(DIM_RST);

  logic [PIX_W-1:0] pixels_to_send [$];
  res_t             sharpened_q [$];

  int unsigned errors;
  int unsigned cycles;
  int unsigned results_checked;
  int unsigned hold_left;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned small_items;

  function automatic int unsigned eff_dim(logic [CFG_DATA_W-1:0] raw, int unsigned maxv);
    if (raw < DIM_MIN) return DIM_MIN;
    if (raw > maxv) return maxv;
    return raw;
  endfunction

  task automatic predict_sharpened(input logic [PIX_W-1:0] pix);
    int unsigned w, h, x, y;
    int          acc;
    logic        last_row;
    logic [PIX_W-1:0] up, centre, right, left;
    res_t        r;
    w = eff_dim(width_reg, MAX_WIDTH_DEF);
    h = eff_dim(height_reg, MAX_HEIGHT_DEF);
    x = cur_col;
    y = cur_row;
    last_row = (y + 1 >= h);
    up     = prev2_line[x];
    centre = prev_line[x];
    right  = (x + 1 < MAX_WIDTH_DEF) ? prev_line[x+1] : '0;
    left   = (x > 0) ? prev2_line[x-1] : '0;
    if (y >= 1) begin
      acc = 0;
      if (y - 1 >= 1 && y < h && x >= 1 && x + 1 < w) begin
        acc = KGAIN * int'(centre) - int'(left) - int'(right) - int'(up) - int'(pix);
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
      end
      r.pix  = PIX_W'(acc);
      r.row  = COORD_W'(y - 1);
      r.col  = COORD_W'(x);
      r.last = !last_row;
      r.eof  = 1'b0;
      sharpened_q.push_back(r);
    end
    if (last_row) begin
      r.pix  = '0;
      r.row  = COORD_W'(y);
      r.col  = COORD_W'(x);
      r.last = 1'b1;
      r.eof  = (x + 1 >= w);
      sharpened_q.push_back(r);
    end
    prev2_line[x] = centre;
    prev_line[x]  = pix;
    if (cur_col + 1 >= w) begin
      cur_col = 0;
      cur_row = last_row ? 0 : y + 1;
    end else begin
      cur_col = cur_col + 1;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_sharpened(pixel_in_i);
      if (!in_valid_i || in_ready_o) begin
        if (pixels_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          pixel_in_i <= pixels_to_send.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk_i) begin : monitor
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (sharpened_q.size() == 0) begin
          $display("%0t: unexpected item, expected none actual pixel %0d row %0d col %0d",
                   $time, pixel_out_o, out_row_o, out_col_o);
          errors++;
        end else begin
          want = sharpened_q.pop_front();
          check_field("pixel_out", want.pix, pixel_out_o);
          check_field("out_row", want.row, out_row_o);
          check_field("out_col", want.col, out_col_o);
          check_field("last_in_run", want.last, last_in_run_o);
          check_field("end_of_frame", want.eof, end_of_frame_o);
        end
        results_checked++;
        // long hold-off so the block backs up into its input
        if (results_checked % 400 == 25) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pixels_to_send.size() != 0 || in_valid_i || sharpened_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH: begin
        width_reg = val;
        cur_row = 0;
        cur_col = 0;
      end
      REG_FRAME_HEIGHT: begin
        height_reg = val;
        cur_row = 0;
        cur_col = 0;
      end
      default: ;
    endcase
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_dim_raw(int unsigned typical_hi);
    int unsigned k;
    k = $urandom_range(0, 19);
    if (k < 2) return CFG_DATA_W'($urandom_range(0, 2));
    if (k == 2) return CFG_DATA_W'($urandom_range(1025, 2047));
    if (k == 3) return CFG_DATA_W'($urandom_range(0, 2047));
    return CFG_DATA_W'($urandom_range(DIM_MIN, typical_hi));
  endfunction

  task automatic run_random_frames();
    int unsigned sel, area, cnt;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom_range(0, 2047)));
    end else if (sel <= 3) begin
      write_reg(REG_FRAME_WIDTH, rand_dim_raw(12));
    end else if (sel <= 5) begin
      write_reg(REG_FRAME_HEIGHT, rand_dim_raw(8));
    end else if (sel <= 7) begin
      write_reg(REG_FRAME_WIDTH, rand_dim_raw(12));
      write_reg(REG_FRAME_HEIGHT, rand_dim_raw(8));
    end else begin
      write_reg(REG_FRAME_HEIGHT, rand_dim_raw(8));
      write_reg(REG_FRAME_WIDTH, rand_dim_raw(12));
    end
    area = eff_dim(width_reg, MAX_WIDTH_DEF) * eff_dim(height_reg, MAX_HEIGHT_DEF);
    if (area > 120) cnt = $urandom_range(1, 40);
    else if ($urandom_range(0, 3) == 0) cnt = $urandom_range(1, 2 * area);
    else cnt = area * $urandom_range(1, 2);
    for (int unsigned i = 0; i < cnt; i++) pixels_to_send.push_back(rand_pixel());
    small_items += cnt;
    wait_idle();
  endtask

  initial begin : stimulus
    int unsigned cnt;
    foreach (prev_line[i]) begin
      prev_line[i]  = '0;
      prev2_line[i] = '0;
    end
    send_idle_pct = 36;
    recv_idle_pct = 51;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first row at reset geometry gives nothing
    pixels_to_send.push_back('0);
    pixels_to_send.push_back('1);
    pixels_to_send.push_back(8'h5a);
    pixels_to_send.push_back(8'ha5);
    wait_idle();

    // undersized geometry clamps to 3x3, restarts mid-row
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
    // bright centre saturates high, dark centre saturates low
    for (int unsigned i = 0; i < 9; i++) pixels_to_send.push_back((i == 4) ? 8'hff : 8'h00);
    for (int unsigned i = 0; i < 9; i++) pixels_to_send.push_back((i == 4) ? 8'h00 : 8'hff);
    wait_idle();

    while (small_items < 270) run_random_frames();

    send_idle_pct = 51;
    recv_idle_pct = 36;
    // full width, oversized height: one whole row plus the start of the next
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(MAX_WIDTH_DEF));
    write_reg(REG_FRAME_HEIGHT, '1);
    cnt = MAX_WIDTH_DEF + $urandom_range(8, 24);
    for (int unsigned i = 0; i < cnt; i++) pixels_to_send.push_back(rand_pixel());
    wait_idle();

    while (small_items < 540) run_random_frames();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (small_items < 810) run_random_frames();

    wait_idle();
    if (sharpened_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sharpen_pkg.sv
rtl/sharpen_ctrl.sv
rtl/sharpen_linebuf.sv
rtl/sharpen_core.sv
rtl/sharpen_outq.sv
rtl/sharpen_3x3_cross_stream.sv
verif/sharpen_3x3_cross_stream_test.sv
